[rtl/rcam_pkg.sv]
// Package for the ring cluster angle match filter.
// Holds word types, codes and fixed constants; used by every RTL file except rcam_ram.
`default_nettype none
package rcam_pkg;

    localparam int unsigned NUM_SECTORS      = 6;
    localparam int unsigned RINGS_PER_SECTOR = 512;
    localparam int unsigned IDX_W            = 12;   // ring index within a sector
    localparam int unsigned LEN_W            = 13;   // ring count within a sector
    localparam logic [16:0] SECTOR_PHI_STEP  = 17'd3840;
    localparam logic [16:0] FULL_TURN        = 17'd23040;
    localparam logic [11:0] TOTAL_MAX        = 12'hFFF;
    localparam logic [31:0] CNT_MAX          = 32'hFFFF_FFFF;

    // function codes
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_CLUSTER = 2'd1;
    localparam logic [1:0] FUNC_EOE     = 2'd2;

    // outcome codes
    localparam logic [1:0] OUT_NO_RINGS = 2'd0;
    localparam logic [1:0] OUT_TOO_FEW  = 2'd1;
    localparam logic [1:0] OUT_ACCEPT   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_DTHETA_LOW  = 3'd0;
    localparam logic [2:0] CFG_DTHETA_HIGH = 3'd1;
    localparam logic [2:0] CFG_DPHI_LOW    = 3'd2;
    localparam logic [2:0] CFG_DPHI_HIGH   = 3'd3;
    localparam logic [2:0] CFG_MIN_MATCHED = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  sector;
        logic [13:0] theta;
        logic [14:0] phi;
        logic        inner_segment;
    } t_in_word;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  outcome;
        logic [11:0] ring_total;
        logic [11:0] matched_total;
        logic [31:0] events_seen;
        logic [31:0] events_with_rings;
        logic [31:0] events_accepted;
        logic [31:0] events_single_match;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic             busy;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic             scan_req;
        logic [LEN_W-1:0] scan_len;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/rcam_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rcam_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

[rtl/rcam_ctrl.sv]
// Scan controller: walks the ring store of one sector for a cluster.
// Depends on rcam_pkg.
`default_nettype none
module rcam_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rcam_pkg::t_dp_sts  i_sts,
    output rcam_pkg::t_ctrl_cmd     o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [rcam_pkg::LEN_W-1:0] r_idx, n_idx;
    logic [rcam_pkg::LEN_W-1:0] r_len, n_len;

    // next state and scan index
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_len   = r_len;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.scan_req) begin
                    n_len   = i_sts.scan_len;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.busy   = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_idx = r_idx[rcam_pkg::IDX_W-1:0];
                n_idx        = r_idx + 1'b1;
                if (n_idx == r_len) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last compare and mark write happen here
                o_cmd.busy = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_len   <= n_len;
        end
    end
endmodule
`default_nettype wire

[rtl/rcam_dp.sv]
// Datapath: config registers, ring store, window compare, counters, result word.
// Depends on rcam_pkg and rcam_ram.
`default_nettype none
module rcam_dp #(
    parameter int unsigned RINGS_PER_SECTOR = rcam_pkg::RINGS_PER_SECTOR
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_acc,
    input  wire rcam_pkg::t_in_word   i_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data,
    input  wire rcam_pkg::t_ctrl_cmd  i_cmd,
    output rcam_pkg::t_dp_sts         o_sts,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output rcam_pkg::t_out_word       o_data
);
    localparam int unsigned DEPTH = rcam_pkg::NUM_SECTORS * RINGS_PER_SECTOR;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(RINGS_PER_SECTOR + 1);
    localparam int unsigned RW    = 30;

    // configuration
    logic signed [14:0] r_dth_lo, r_dth_hi;
    logic signed [15:0] r_dph_lo, r_dph_hi;
    logic [11:0]        r_min_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dth_lo    <= -15'sd320;
            r_dth_hi    <= 15'sd320;
            r_dph_lo    <= -16'sd192;
            r_dph_hi    <= 16'sd192;
            r_min_match <= 12'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcam_pkg::CFG_DTHETA_LOW:  r_dth_lo    <= i_cfg_data[14:0];
                rcam_pkg::CFG_DTHETA_HIGH: r_dth_hi    <= i_cfg_data[14:0];
                rcam_pkg::CFG_DPHI_LOW:    r_dph_lo    <= i_cfg_data;
                rcam_pkg::CFG_DPHI_HIGH:   r_dph_hi    <= i_cfg_data;
                rcam_pkg::CFG_MIN_MATCHED: r_min_match <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // decode of the accepted word
    logic            sec_ok;
    logic [CW-1:0]   sec_cnt;
    logic            do_load, do_cluster, do_eoe;
    logic [16:0]     gphi_sum, gphi;
    logic [CW-1:0]   r_cnt [rcam_pkg::NUM_SECTORS];

    assign sec_ok  = (i_data.sector < 3'(rcam_pkg::NUM_SECTORS));
    assign sec_cnt = sec_ok ? r_cnt[i_data.sector] : '0;

    assign do_load    = i_acc && (i_data.func == rcam_pkg::FUNC_LOAD) && sec_ok
                        && (sec_cnt < CW'(RINGS_PER_SECTOR));
    assign do_cluster = i_acc && (i_data.func == rcam_pkg::FUNC_CLUSTER) && sec_ok
                        && i_data.inner_segment && (sec_cnt != '0);
    assign do_eoe     = i_acc && (i_data.func == rcam_pkg::FUNC_EOE);

    assign o_sts.scan_req = do_cluster;
    assign o_sts.scan_len = rcam_pkg::LEN_W'(sec_cnt);

    // global phi of the cluster, wrapped once
    assign gphi_sum = 17'(i_data.phi) + 17'(i_data.sector) * rcam_pkg::SECTOR_PHI_STEP;
    assign gphi     = (gphi_sum > rcam_pkg::FULL_TURN) ? gphi_sum - rcam_pkg::FULL_TURN
                                                        : gphi_sum;

    // hold cluster angles for the scan
    logic [2:0]  r_cl_sec;
    logic [13:0] r_cl_theta;
    logic [16:0] r_cl_gphi;

    always_ff @(posedge i_clk) begin
        if (do_cluster) begin
            r_cl_sec   <= i_data.sector;
            r_cl_theta <= i_data.theta;
            r_cl_gphi  <= gphi;
        end
    end

    // ring store: {matched mark, phi, theta}
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr, load_addr, r_cmp_addr;
    logic [RW-1:0] ram_wdata, ram_q;
    logic          r_cmp_vld;

    assign load_addr = AW'(i_data.sector) * AW'(RINGS_PER_SECTOR) + AW'(sec_cnt);
    assign ram_raddr = AW'(r_cl_sec) * AW'(RINGS_PER_SECTOR) + AW'(i_cmd.rd_idx);

    rcam_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
        end
        r_cmp_addr <= ram_raddr;
    end

    // window compare on the ring just read
    logic signed [17:0] dph;
    logic signed [15:0] dth;
    logic               hit, set_mark;

    assign dph = $signed({3'b000, ram_q[28:14]}) - $signed({1'b0, r_cl_gphi});
    assign dth = $signed({2'b00, ram_q[13:0]}) - $signed({2'b00, r_cl_theta});
    assign hit = (dph >= 18'(r_dph_lo)) && (dph <= 18'(r_dph_hi))
                 && (dth >= 16'(r_dth_lo)) && (dth <= 16'(r_dth_hi));
    assign set_mark = r_cmp_vld && hit && !ram_q[29];

    // write port: mark update during scan, ring load otherwise
    always_comb begin
        ram_we    = set_mark || do_load;
        ram_waddr = set_mark ? r_cmp_addr : load_addr;
        ram_wdata = set_mark ? {1'b1, ram_q[28:0]}
                             : {1'b0, i_data.phi, i_data.theta};
    end

    // event counters and result word
    logic [11:0] r_ring_total, r_matched;
    logic [31:0] r_evt [4];
    logic        r_out_valid;
    rcam_pkg::t_out_word r_out, n_out;

    always_comb begin
        n_out               = '0;
        n_out.ring_total    = r_ring_total;
        n_out.matched_total = r_matched;
        n_out.events_seen   = (r_evt[0] != rcam_pkg::CNT_MAX) ? r_evt[0] + 1'b1 : r_evt[0];
        n_out.events_with_rings   = r_evt[1];
        n_out.events_accepted     = r_evt[2];
        n_out.events_single_match = r_evt[3];
        if (r_ring_total == '0) begin
            n_out.outcome = rcam_pkg::OUT_NO_RINGS;
        end else begin
            n_out.events_with_rings = (r_evt[1] != rcam_pkg::CNT_MAX) ? r_evt[1] + 1'b1
                                                                       : r_evt[1];
            if (r_matched < r_min_match) begin
                n_out.outcome = rcam_pkg::OUT_TOO_FEW;
            end else begin
                n_out.outcome  = rcam_pkg::OUT_ACCEPT;
                n_out.accepted = 1'b1;
                n_out.events_accepted = (r_evt[2] != rcam_pkg::CNT_MAX) ? r_evt[2] + 1'b1
                                                                         : r_evt[2];
                if (r_matched == 12'd1 && r_evt[3] != rcam_pkg::CNT_MAX) begin
                    n_out.events_single_match = r_evt[3] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_total <= '0;
            r_matched    <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_evt[i] <= '0;
            end
            for (int s = 0; s < rcam_pkg::NUM_SECTORS; s++) begin
                r_cnt[s] <= '0;
            end
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (do_load) begin
                r_cnt[i_data.sector] <= sec_cnt + 1'b1;
                if (r_ring_total != rcam_pkg::TOTAL_MAX) begin
                    r_ring_total <= r_ring_total + 1'b1;
                end
            end
            if (set_mark && r_matched != rcam_pkg::TOTAL_MAX) begin
                r_matched <= r_matched + 1'b1;
            end
            if (do_eoe) begin
                r_out_valid  <= 1'b1;
                r_evt[0]     <= n_out.events_seen;
                r_evt[1]     <= n_out.events_with_rings;
                r_evt[2]     <= n_out.events_accepted;
                r_evt[3]     <= n_out.events_single_match;
                r_ring_total <= '0;
                r_matched    <= '0;
                for (int s = 0; s < rcam_pkg::NUM_SECTORS; s++) begin
                    r_cnt[s] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_eoe) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
endmodule
`default_nettype wire

[rtl/ring_cluster_angle_match_filter.sv]
// Top level of the ring cluster angle match filter.
// Depends on rcam_pkg, rcam_ctrl, rcam_dp (and rcam_ram below it).
//
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_data (rcam_pkg::t_in_word)
//  output  | o_valid | i_stall | o_data (rcam_pkg::t_out_word)
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data (write only, no wait)
//
// Ring loads, ignored words and end of event need no ring store scan.
// A matching inner cluster scans the N rings stored in its sector (at most
// RINGS_PER_SECTOR), one ring store read per cycle, then passes a drain state.
// Reset is synchronous, active low; the ring store needs no clearing pass.
// Every input word is held off while a previous result word is still stalled.
`default_nettype none
module ring_cluster_angle_match_filter #(
    parameter int unsigned RINGS_PER_SECTOR = rcam_pkg::RINGS_PER_SECTOR
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire rcam_pkg::t_in_word   i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output rcam_pkg::t_out_word       o_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data
);
    rcam_pkg::t_ctrl_cmd cmd;
    rcam_pkg::t_dp_sts   sts;
    logic                acc;

    // hold input while scanning or while the result word cannot move
    assign o_stall = cmd.busy || (o_valid && i_stall);
    assign acc     = i_valid && !o_stall;

    rcam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rcam_dp #(.RINGS_PER_SECTOR(RINGS_PER_SECTOR)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );
endmodule
`default_nettype wire

[rtl/rcam_checker.sv]
// Port checker for the ring cluster angle match filter, bound to the top level.
// Depends on rcam_pkg.
`default_nettype none
module rcam_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire rcam_pkg::t_out_word o_data
);
    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    // accept flag agrees with outcome
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.accepted == (o_data.outcome == rcam_pkg::OUT_ACCEPT)))
        else $error("accepted and outcome disagree");

    // matched rings never exceed stored rings
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.matched_total <= o_data.ring_total)
        else $error("more matched rings than rings");

    // statistics stay ordered
    a_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.events_with_rings <= o_data.events_seen)
                 && (o_data.events_accepted <= o_data.events_with_rings)
                 && (o_data.events_single_match <= o_data.events_accepted))
        else $error("event statistics out of order");
endmodule

bind ring_cluster_angle_match_filter rcam_checker u_rcam_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
`default_nettype wire

[verif/rcam_scoreboard.sv]
// Scoreboard for the ring cluster angle match filter: watches the three ports,
// keeps its own copy of ring store, windows and event counters. Needs rcam_pkg.
`timescale 1ns / 100ps
`default_nettype none
module rcam_scoreboard (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire rcam_pkg::t_in_word  i_in_data,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire rcam_pkg::t_out_word i_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [15:0]         i_cfg_data,
    output int                       o_errors,
    output int                       o_pending
);
    localparam int SLOTS   = int'(rcam_pkg::RINGS_PER_SECTOR);
    localparam int SECTORS = int'(rcam_pkg::NUM_SECTORS);

    // window registers as the block should hold them
    int          theta_lo, theta_hi, phi_lo, phi_hi;
    int unsigned min_matched;

    // ring store and event state
    logic [13:0] theta_mem [SECTORS][SLOTS];
    logic [14:0] phi_mem   [SECTORS][SLOTS];
    bit          matched_mark [SECTORS][SLOTS];
    int unsigned ring_count [SECTORS];
    int unsigned matched_count;
    logic [31:0] n_seen, n_with_rings, n_accepted, n_single;

    rcam_pkg::t_out_word expected_summaries [$];

    assign o_pending = expected_summaries.size();

    task automatic report(string field, longint unsigned want, longint unsigned got);
        $display("[%0t] event summary %s: expected %0d, got %0d", $realtime, field, want, got);
        o_errors++;
    endtask

    function automatic logic [31:0] bump(logic [31:0] c);
        return (c == rcam_pkg::CNT_MAX) ? c : c + 32'd1;
    endfunction

    // advance the filter state by one word, queue a summary on end of event
    task automatic apply_word(rcam_pkg::t_in_word w);
        int                  gphi, dph, dth;
        int unsigned         total;
        rcam_pkg::t_out_word s;
        case (w.func)
            rcam_pkg::FUNC_LOAD: begin
                if (w.sector < SECTORS && ring_count[w.sector] < SLOTS) begin
                    theta_mem[w.sector][ring_count[w.sector]] = w.theta;
                    phi_mem[w.sector][ring_count[w.sector]] = w.phi;
                    matched_mark[w.sector][ring_count[w.sector]] = 1'b0;
                    ring_count[w.sector]++;
                end
            end
            rcam_pkg::FUNC_CLUSTER: begin
                if (w.inner_segment && w.sector < SECTORS) begin
                    gphi = int'(w.phi) + int'(w.sector) * int'(rcam_pkg::SECTOR_PHI_STEP);
                    if (gphi > int'(rcam_pkg::FULL_TURN))
                        gphi -= int'(rcam_pkg::FULL_TURN);
                    for (int r = 0; r < ring_count[w.sector]; r++) begin
                        dph = int'(phi_mem[w.sector][r]) - gphi;
                        dth = int'(theta_mem[w.sector][r]) - int'(w.theta);
                        if (dph >= phi_lo && dph <= phi_hi && dth >= theta_lo &&
                            dth <= theta_hi && !matched_mark[w.sector][r]) begin
                            matched_mark[w.sector][r] = 1'b1;
                            if (matched_count < int'(rcam_pkg::TOTAL_MAX))
                                matched_count++;
                        end
                    end
                end
            end
            rcam_pkg::FUNC_EOE: begin
                total = 0;
                foreach (ring_count[k])
                    total += ring_count[k];
                if (total > int'(rcam_pkg::TOTAL_MAX))
                    total = int'(rcam_pkg::TOTAL_MAX);
                n_seen = bump(n_seen);
                s.accepted = 1'b0;
                if (total == 0) begin
                    s.outcome = rcam_pkg::OUT_NO_RINGS;
                end else begin
                    n_with_rings = bump(n_with_rings);
                    if (matched_count < min_matched) begin
                        s.outcome = rcam_pkg::OUT_TOO_FEW;
                    end else begin
                        s.outcome = rcam_pkg::OUT_ACCEPT;
                        s.accepted = 1'b1;
                        n_accepted = bump(n_accepted);
                        if (matched_count == 1)
                            n_single = bump(n_single);
                    end
                end
                s.ring_total = total[11:0];
                s.matched_total = matched_count[11:0];
                s.events_seen = n_seen;
                s.events_with_rings = n_with_rings;
                s.events_accepted = n_accepted;
                s.events_single_match = n_single;
                expected_summaries.push_back(s);
                foreach (ring_count[k])
                    ring_count[k] = 0;
                matched_count = 0;
            end
            default: ;
        endcase
    endtask

    // compare a delivered summary with the oldest one predicted
    task automatic check_summary(rcam_pkg::t_out_word got);
        rcam_pkg::t_out_word want;
        if (expected_summaries.size() == 0) begin
            $display("[%0t] event summary with none pending", $realtime);
            o_errors++;
            return;
        end
        want = expected_summaries.pop_front();
        if (got.accepted !== want.accepted)
            report("accepted", want.accepted, got.accepted);
        if (got.outcome !== want.outcome)
            report("outcome", want.outcome, got.outcome);
        if (got.ring_total !== want.ring_total)
            report("ring_total", want.ring_total, got.ring_total);
        if (got.matched_total !== want.matched_total)
            report("matched_total", want.matched_total, got.matched_total);
        if (got.events_seen !== want.events_seen)
            report("events_seen", want.events_seen, got.events_seen);
        if (got.events_with_rings !== want.events_with_rings)
            report("events_with_rings", want.events_with_rings, got.events_with_rings);
        if (got.events_accepted !== want.events_accepted)
            report("events_accepted", want.events_accepted, got.events_accepted);
        if (got.events_single_match !== want.events_single_match)
            report("events_single_match", want.events_single_match,
                   got.events_single_match);
    endtask

    initial o_errors = 0;

    // sample all ports at the edge; results first, then the incoming word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            theta_lo = -320;
            theta_hi = 320;
            phi_lo = -192;
            phi_hi = 192;
            min_matched = 1;
            foreach (ring_count[k])
                ring_count[k] = 0;
            matched_count = 0;
            n_seen = '0;
            n_with_rings = '0;
            n_accepted = '0;
            n_single = '0;
            expected_summaries.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rcam_pkg::CFG_DTHETA_LOW:  theta_lo = $signed(i_cfg_data[14:0]);
                    rcam_pkg::CFG_DTHETA_HIGH: theta_hi = $signed(i_cfg_data[14:0]);
                    rcam_pkg::CFG_DPHI_LOW:    phi_lo = $signed(i_cfg_data);
                    rcam_pkg::CFG_DPHI_HIGH:   phi_hi = $signed(i_cfg_data);
                    rcam_pkg::CFG_MIN_MATCHED: min_matched = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall)
                check_summary(i_out_data);
            if (i_in_valid && !i_in_stall)
                apply_word(i_in_data);
        end
    end
endmodule
`default_nettype wire

[verif/ring_cluster_angle_match_filter_tb.sv]
// Testbench top for the ring cluster angle match filter: drives rings, clusters
// and end-of-event words under several window settings. Needs rcam_pkg, the RTL
// and rcam_scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module ring_cluster_angle_match_filter_tb;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [2:0] CFG_SPARE  = 3'd5;
    localparam int         IDLE_LIMIT = 5000;

    typedef struct {
        int sector;
        int theta;
        int phi;
    } t_ring;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    rcam_pkg::t_in_word  i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    rcam_pkg::t_out_word o_data;
    logic                i_cfg_we = 1'b0;
    logic [2:0]          i_cfg_idx = '0;
    logic [15:0]         i_cfg_data = '0;
    int                  errors, pending;
    int                  words_sent = 0;
    int                  idle_cycles = 0;
    int                  stall_left = 0;
    bit                  burst_mode = 1'b0;
    t_ring               event_rings [$];

    always #2 i_clk = ~i_clk;

    ring_cluster_angle_match_filter DUT (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid, .i_stall, .o_data, .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    rcam_scoreboard u_scoreboard (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_data(o_data),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int draw_wait();
        return burst_mode ? 0 : int'($urandom_range(0, 13));
    endfunction

    // hold each summary for a random number of cycles before taking it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (o_valid && !i_stall) begin
            stall_left = draw_wait();
            i_stall <= (stall_left != 0);
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= (stall_left > 0);
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ring_cluster_angle_match_filter: mismatch");
            $finish;
        end
    end

    // present one word after a random gap and hold it until taken
    task automatic send(logic [1:0] func, int sector, int theta, int phi, bit inner);
        int                 gap;
        bit                 taken;
        rcam_pkg::t_in_word w;
        gap = draw_wait();
        w.func = func;
        w.sector = sector[2:0];
        w.theta = theta[13:0];
        w.phi = phi[14:0];
        w.inner_segment = inner;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        words_sent++;
        if (func == rcam_pkg::FUNC_LOAD && sector < rcam_pkg::NUM_SECTORS)
            event_rings.push_back('{sector, theta, phi});
        if (func == rcam_pkg::FUNC_EOE)
            event_rings.delete();
    endtask

    task automatic write_reg(logic [2:0] idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[15:0];
        @(posedge i_clk);
    endtask

    task automatic set_windows(int th_lo, int th_hi, int ph_lo, int ph_hi, int min_rings);
        write_reg(rcam_pkg::CFG_DTHETA_LOW, th_lo);
        write_reg(rcam_pkg::CFG_DTHETA_HIGH, th_hi);
        write_reg(rcam_pkg::CFG_DPHI_LOW, ph_lo);
        write_reg(rcam_pkg::CFG_DPHI_HIGH, ph_hi);
        write_reg(rcam_pkg::CFG_MIN_MATCHED, min_rings);
        write_reg(CFG_SPARE, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // drain the block so the windows may change
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (600) @(posedge i_clk);
    endtask

    // cluster placed near a stored ring, in that ring's local phi
    task automatic send_near_cluster();
        t_ring r;
        int    th, gphi, lphi;
        r = event_rings[$urandom_range(0, event_rings.size() - 1)];
        th = r.theta + int'($urandom_range(0, 800)) - 400;
        gphi = r.phi + int'($urandom_range(0, 600)) - 300;
        lphi = gphi - r.sector * int'(rcam_pkg::SECTOR_PHI_STEP);
        if (lphi < 0)
            lphi += int'(rcam_pkg::FULL_TURN);
        if (th < 0) th = 0;
        if (th > 16383) th = 16383;
        if (lphi > 32767) lphi = 32767;
        send(rcam_pkg::FUNC_CLUSTER, r.sector, th, lphi, $urandom_range(0, 7) != 0);
    endtask

    function automatic int rand_sector();
        return ($urandom_range(0, 15) == 0) ? int'($urandom_range(6, 7))
                                            : int'($urandom_range(0, 5));
    endfunction

    // one event: a mix of ring loads and clusters, closed by end of event
    task automatic random_event();
        int n_steps;
        n_steps = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 18));
        for (int k = 0; k < n_steps; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    if ($urandom_range(0, 5) == 0)
                        send(rcam_pkg::FUNC_LOAD, rand_sector(), $urandom_range(0, 16383),
                             $urandom_range(0, 32767), $urandom_range(0, 1));
                    else
                        send(rcam_pkg::FUNC_LOAD, rand_sector(), $urandom_range(0, 11520),
                             $urandom_range(0, 23040), $urandom_range(0, 1));
                end
                4, 5, 6, 7: begin
                    if (event_rings.size() > 0)
                        send_near_cluster();
                    else
                        send(rcam_pkg::FUNC_CLUSTER, rand_sector(),
                             $urandom_range(0, 11520), $urandom_range(0, 3840), 1'b1);
                end
                8: send(rcam_pkg::FUNC_CLUSTER, rand_sector(), $urandom_range(0, 16383),
                        $urandom_range(0, 32767), $urandom_range(0, 1));
                default: send($urandom_range(0, 9) == 0 ? FUNC_SPARE : rcam_pkg::FUNC_LOAD,
                              rand_sector(), $urandom_range(0, 16383),
                              $urandom_range(0, 32767), $urandom_range(0, 1));
            endcase
        end
        send(rcam_pkg::FUNC_EOE, $urandom_range(0, 7), $urandom_range(0, 16383),
             $urandom_range(0, 32767), $urandom_range(0, 1));
    endtask

    task automatic random_phase(int words);
        int stop_at;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0)
                burst_mode = !burst_mode;
            random_event();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, sector wrap, ignored words
        set_windows(-320, 320, -192, 192, 1);
        send(rcam_pkg::FUNC_LOAD, 0, 0, 0, 1'b0);
        send(rcam_pkg::FUNC_LOAD, 5, 11520, 23040, 1'b1);
        send(rcam_pkg::FUNC_LOAD, 7, 100, 100, 1'b0);
        send(rcam_pkg::FUNC_LOAD, 6, 16383, 32767, 1'b1);
        send(rcam_pkg::FUNC_CLUSTER, 0, 0, 0, 1'b1);
        send(rcam_pkg::FUNC_CLUSTER, 0, 10, 20, 1'b1);
        send(rcam_pkg::FUNC_CLUSTER, 5, 11520, 3840, 1'b0);
        send(rcam_pkg::FUNC_CLUSTER, 5, 11520, 3840, 1'b1);
        send(rcam_pkg::FUNC_CLUSTER, 5, 11520, 3841, 1'b1);
        send(rcam_pkg::FUNC_CLUSTER, 7, 0, 0, 1'b1);
        send(FUNC_SPARE, 0, 0, 0, 1'b1);
        send(rcam_pkg::FUNC_CLUSTER, 4, 16383, 32767, 1'b1);
        send(rcam_pkg::FUNC_EOE, 0, 0, 0, 1'b0);
        send(rcam_pkg::FUNC_EOE, 7, 16383, 32767, 1'b1);
        send(rcam_pkg::FUNC_LOAD, 1, 16383, 32767, 1'b1);
        send(rcam_pkg::FUNC_CLUSTER, 1, 16383, 28927, 1'b1);
        send(rcam_pkg::FUNC_EOE, 1, 0, 0, 1'b0);
        random_phase(70);
        settle();

        // widest windows, no matches needed; fill one sector past its store
        set_windows(-11520, 11520, -23040, 23040, 0);
        for (int k = 0; k < int'(rcam_pkg::RINGS_PER_SECTOR) + 2; k++) begin
            burst_mode = (k % 64) < 20;
            send(rcam_pkg::FUNC_LOAD, 2, $urandom_range(0, 11520),
                 $urandom_range(0, 23040), 1'b0);
        end
        send(rcam_pkg::FUNC_CLUSTER, 2, 5000, 100, 1'b1);
        send(rcam_pkg::FUNC_EOE, 2, 0, 0, 1'b0);
        random_phase(110);
        settle();

        // zero-width windows and an unreachable match count
        set_windows(0, 0, 0, 0, 3072);
        random_phase(110);
        settle();

        // inverted windows never match
        set_windows(5, -5, 3, -3, 2);
        random_phase(100);
        settle();

        // random windows, small match counts
        set_windows(-int'($urandom_range(0, 11520)), $urandom_range(0, 11520),
                    -int'($urandom_range(0, 23040)), $urandom_range(0, 23040),
                    $urandom_range(0, 4));
        random_phase(100);
        settle();
        set_windows(-320, 320, -192, 192, 1);
        random_phase(110);

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("ring_cluster_angle_match_filter: match");
        else
            $display("ring_cluster_angle_match_filter: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
rtl/rcam_pkg.sv
rtl/rcam_ram.sv
rtl/rcam_ctrl.sv
rtl/rcam_dp.sv
rtl/ring_cluster_angle_match_filter.sv
rtl/rcam_checker.sv
verif/rcam_scoreboard.sv
verif/ring_cluster_angle_match_filter_tb.sv
